>>> hdl/iirf_pkg.sv
// Shared types, sizes and constants for the direct-form I IIR filter.
`timescale 1ns / 1ps

package iirf_pkg;

  // Tap counts: FF_TAPS feed-forward taps, FB_TAPS-1 feedback taps
  localparam int FF_TAPS     = 4;
  localparam int FB_TAPS     = 4;
  localparam int NUM_FF_REGS = 4;
  localparam int NUM_FB_REGS = 3;

  // Datapath widths
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + $clog2(FF_TAPS + FB_TAPS) + 1;
  localparam int FRAC_BITS = 14;

  // Configuration register map
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_FF_BASE = 0;
  localparam int CFG_FB_BASE = NUM_FF_REGS;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Per-cell control: shift the tap register, and zero the history it sees
  typedef struct packed {
    logic advance;
    logic clear;
  } tap_ctl_t;

  // Rounding and saturation constants in accumulator width
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);
  localparam acc_t SAT_MAX    = acc_t'((2 ** (SAMPLE_W - 1)) - 1);
  localparam acc_t SAT_MIN    = -acc_t'(2 ** (SAMPLE_W - 1));

  // Reset value of feed-forward coefficient k
  function automatic coef_t ff_coef_reset(int k);
    coef_t v;
    v = '0;
    if (k == 0) v = COEF_W'(8192);
    if (k == 1) v = COEF_W'(3277);
    return v;
  endfunction

  // Reset value of feedback coefficient j (j starts at 1)
  function automatic coef_t fb_coef_reset(int j);
    coef_t v;
    v = '0;
    if (j == 1) v = COEF_W'(-8192);
    return v;
  endfunction

endpackage

>>> hdl/iirf_tap_cell.sv
// One filter tap: history register handed on to the next cell, plus its product.
`timescale 1ns / 1ps

module iirf_tap_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  iirf_pkg::tap_ctl_t ctl,
  input  iirf_pkg::coef_t    coef,
  input  iirf_pkg::sample_t  sample_in,
  output iirf_pkg::sample_t  sample_out,
  output iirf_pkg::prod_t    product
);
  import iirf_pkg::*;

  sample_t eff_sample;
  sample_t sample_r;

  // History seen by this tap; zero at a stream start
  assign eff_sample = ctl.clear ? '0 : sample_in;
  assign product    = coef * eff_sample;

  // Tap register shifts toward the next cell on each advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (ctl.advance) begin
      sample_r <= eff_sample;
    end
  end

  assign sample_out = sample_r;

endmodule

>>> hdl/iirf_coef_regs.sv
// Coefficient register file written through the configuration port.
`timescale 1ns / 1ps

module iirf_coef_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr,
  input  logic [iirf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  iirf_pkg::coef_t                cfg_data,
  output iirf_pkg::coef_t                ff_coef [iirf_pkg::FF_TAPS],
  output iirf_pkg::coef_t                fb_coef [iirf_pkg::FB_TAPS-1]
);
  import iirf_pkg::*;

  coef_t ff_coef_r [FF_TAPS];
  coef_t fb_coef_r [FB_TAPS-1];

  // Feed-forward coefficients; taps without a register stay zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FF_TAPS; k++) begin
        ff_coef_r[k] <= ff_coef_reset(k);
      end
    end else if (cfg_wr) begin
      for (int k = 0; k < FF_TAPS; k++) begin
        if (k < NUM_FF_REGS && cfg_index == CFG_IDX_W'(CFG_FF_BASE + k)) begin
          ff_coef_r[k] <= cfg_data;
        end
      end
    end
  end

  // Feedback coefficients; entry j-1 weights the output j samples back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j < FB_TAPS; j++) begin
        fb_coef_r[j-1] <= fb_coef_reset(j);
      end
    end else if (cfg_wr) begin
      for (int j = 1; j < FB_TAPS; j++) begin
        if (j <= NUM_FB_REGS && cfg_index == CFG_IDX_W'(CFG_FB_BASE + j - 1)) begin
          fb_coef_r[j-1] <= cfg_data;
        end
      end
    end
  end

  assign ff_coef = ff_coef_r;
  assign fb_coef = fb_coef_r;

endmodule

>>> hdl/iir_direct_form_filter.sv
// Direct-form I IIR filter, Q1.15 samples and Q2.14 coefficients, one output
// word per input word, one word per clock while the output is not stalled;
// each word passes the stage 1, stage 2 and output registers. Feed-forward
// taps form a chain of cells whose products are registered at accept and
// summed in the next stage; the feedback cells close their loop in the output
// stage, where the last output times the first feedback coefficient, the
// summing, the round to nearest, the shift by 14 and the saturation all sit
// in one combinational path, which is the path that sets the clock rate. A
// start flag in in_tuser clears both histories before its word is filtered.
// Coefficients should be written only while no word is in flight.
`timescale 1ns / 1ps

module iir_direct_form_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // [15:0] in_sample
  input  logic [0:0]                     in_tuser,   // [0] stream_start
  // Output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [15:0] out_sample
  output logic [0:0]                     out_tuser,  // [0] clipped
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iirf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import iirf_pkg::*;

  coef_t    ff_coef [FF_TAPS];
  coef_t    fb_coef [FB_TAPS-1];

  logic     in_accept;
  logic     ready_out, ready_s2, ready_s1;
  logic     xfer_s1, xfer_s2;

  // Stage 1: registered feed-forward products
  logic     s1_valid_r;
  logic     s1_start_r;
  prod_t    ff_prod_r [FF_TAPS];
  prod_t    ff_prod [FF_TAPS];
  sample_t  ff_link [FF_TAPS+1];
  tap_ctl_t ff_ctl [FF_TAPS];

  // Stage 2: feed-forward sum
  logic     s2_valid_r;
  logic     s2_start_r;
  acc_t     ff_sum_r;
  acc_t     ff_sum_nxt;

  // Output stage and feedback chain
  prod_t    fb_prod [FB_TAPS-1];
  sample_t  fb_link [FB_TAPS];
  tap_ctl_t fb_ctl [FB_TAPS-1];
  acc_t     fb_sum;
  acc_t     acc;
  acc_t     rounded;
  acc_t     quot;
  sample_t  y_nxt;
  logic     clip_nxt;
  logic     out_valid_r;
  sample_t  out_sample_r;
  logic     out_clip_r;

  // Coefficient registers
  assign cfg_ready = 1'b1;

  iirf_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (coef_t'(cfg_data)),
    .ff_coef   (ff_coef),
    .fb_coef   (fb_coef)
  );

  // Handshake: each stage moves on when the next one is empty or moving
  assign ready_out = !out_valid_r || out_tready;
  assign ready_s2  = !s2_valid_r || ready_out;
  assign ready_s1  = !s1_valid_r || ready_s2;
  assign xfer_s2   = s2_valid_r && ready_out;
  assign xfer_s1   = s1_valid_r && ready_s2;
  assign in_tready = ready_s1;
  assign in_accept = in_tvalid && in_tready;

  // Feed-forward chain: cell k sees the input k samples back
  assign ff_link[0] = sample_t'(in_tdata);

  for (genvar k = 0; k < FF_TAPS; k++) begin : g_ff
    assign ff_ctl[k] = '{advance: in_accept, clear: (k != 0) && in_tuser[0]};

    iirf_tap_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ff_ctl[k]),
      .coef       (ff_coef[k]),
      .sample_in  (ff_link[k]),
      .sample_out (ff_link[k+1]),
      .product    (ff_prod[k])
    );
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (xfer_s1) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_start_r <= in_tuser[0];
      ff_prod_r  <= ff_prod;
    end
  end

  // Feed-forward sum
  always_comb begin
    ff_sum_nxt = '0;
    for (int k = 0; k < FF_TAPS; k++) begin
      ff_sum_nxt = ff_sum_nxt + acc_t'(ff_prod_r[k]);
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (xfer_s1) begin
      s2_valid_r <= 1'b1;
    end else if (xfer_s2) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_s1) begin
      s2_start_r <= s1_start_r;
      ff_sum_r   <= ff_sum_nxt;
    end
  end

  // Feedback chain: cell j sees the output j+1 samples back
  assign fb_link[0] = out_sample_r;

  for (genvar j = 0; j < FB_TAPS - 1; j++) begin : g_fb
    assign fb_ctl[j] = '{advance: xfer_s2, clear: s2_start_r};

    iirf_tap_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (fb_ctl[j]),
      .coef       (fb_coef[j]),
      .sample_in  (fb_link[j]),
      .sample_out (fb_link[j+1]),
      .product    (fb_prod[j])
    );
  end

  // Subtract feedback, round to nearest, scale and saturate
  always_comb begin
    fb_sum = '0;
    for (int j = 0; j < FB_TAPS - 1; j++) begin
      fb_sum = fb_sum + acc_t'(fb_prod[j]);
    end
    acc     = ff_sum_r - fb_sum;
    rounded = acc + ROUND_HALF;
    quot    = rounded >>> FRAC_BITS;
    if (quot > SAT_MAX) begin
      y_nxt    = SAT_MAX[SAMPLE_W-1:0];
      clip_nxt = 1'b1;
    end else if (quot < SAT_MIN) begin
      y_nxt    = SAT_MIN[SAMPLE_W-1:0];
      clip_nxt = 1'b1;
    end else begin
      y_nxt    = quot[SAMPLE_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  // Output register; the sample also serves as the newest output history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_sample_r <= '0;
    end else if (xfer_s2) begin
      out_valid_r  <= 1'b1;
      out_sample_r <= y_nxt;
    end else if (out_tready) begin
      out_valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_s2) begin
      out_clip_r <= clip_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_clip_r;

`ifndef SYNTHESIS
  // A clipped word carries a full-scale value
  a_clip_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clip_r |-> (out_sample_r == 16'h7fff || out_sample_r == 16'h8000))
    else $error("clipped word is not full scale");

  // An empty first stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty first stage");

  // A word leaving stage 2 shows up at the output
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    xfer_s2 |=> out_valid_r)
    else $error("stage 2 word lost");

  // A stream start clears the older input and output history
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser[0] |=> ff_link[2] == '0) and
    (xfer_s2 && s2_start_r |=> fb_link[1] == '0))
    else $error("history not cleared at stream start");
`endif

endmodule

>>> test/iir_direct_form_filter_test.sv
// Self-checking bench for the direct-form I IIR filter: directed table, random streams, scoreboard.
`timescale 1ns / 1ps

module iir_direct_form_filter_test;
  import iirf_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 8;   // extra wait after the last output is back
  localparam int STALL_LIMIT    = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int SEG_WORDS      = 150;
  localparam int SEGS_PER_PHASE = 4;
  localparam int NUM_PHASES     = 3;

  // Register map
  localparam int REG_FF_COEF_0 = CFG_FF_BASE;
  localparam int REG_FF_COEF_1 = CFG_FF_BASE + 1;
  localparam int REG_FF_COEF_2 = CFG_FF_BASE + 2;
  localparam int REG_FF_COEF_3 = CFG_FF_BASE + 3;
  localparam int REG_FB_COEF_1 = CFG_FB_BASE;
  localparam int REG_FB_COEF_2 = CFG_FB_BASE + 1;
  localparam int REG_FB_COEF_3 = CFG_FB_BASE + 2;
  localparam int REG_UNMAPPED  = (2 ** CFG_IDX_W) - 1;

  localparam sample_t S_MAX = 16'sh7fff;
  localparam sample_t S_MIN = 16'sh8000;
  localparam coef_t   C_MAX = 16'sh7fff;
  localparam coef_t   C_MIN = 16'sh8000;
  localparam coef_t   C_ONE = 16'sh4000;   // 1.0 in Q2.14

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] value;      // sample or register data
    logic        start;
    int unsigned reg_idx;
    logic        typed;      // expected output given in the row
    sample_t     exp_sample;
    logic        exp_clip;
  } plan_row_t;

  typedef struct {
    sample_t sample;
    logic    clip;
  } filt_out_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // [15:0] in_sample
  logic [0:0]           in_tuser   = '0;   // [0] stream_start
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;         // [15:0] out_sample
  logic [0:0]           out_tuser;         // [0] clipped
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [15:0]          cfg_data   = '0;

  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        holds_asked   = 0;
  int        holds_served  = 0;
  int        hold_left     = 0;
  int        quiet_cycles  = 0;
  int        mismatches    = 0;
  plan_row_t plan[$];
  filt_out_t pending_outputs[$];

  iir_direct_form_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of coefficients and both histories
  // ---------------------------------------------------------------------------
  coef_t   ff_w   [0:FF_TAPS-1];
  coef_t   fb_w   [1:FB_TAPS-1];
  sample_t x_hist [0:FF_TAPS-2];
  sample_t y_hist [0:FB_TAPS-2];

  function automatic void clear_history();
    foreach (x_hist[k]) x_hist[k] = '0;
    foreach (y_hist[k]) y_hist[k] = '0;
  endfunction

  function automatic void coef_defaults();
    foreach (ff_w[k]) ff_w[k] = '0;
    foreach (fb_w[j]) fb_w[j] = '0;
    ff_w[0] = 16'sd8192;
    ff_w[1] = 16'sd3277;
    fb_w[1] = -16'sd8192;
    clear_history();
  endfunction

  // Register write as the block sees it; the spare index is dropped
  function automatic void apply_coef(input int unsigned idx, input logic [15:0] v);
    if (idx < CFG_FB_BASE) begin
      ff_w[idx - CFG_FF_BASE] = coef_t'(v);
    end else if (idx < CFG_FB_BASE + NUM_FB_REGS) begin
      fb_w[idx - CFG_FB_BASE + 1] = coef_t'(v);
    end
  endfunction

  function automatic void iir_step(input sample_t x, input logic start,
                                   output sample_t y, output logic clip);
    longint acc;
    longint q;
    if (start) clear_history();
    acc = longint'(ff_w[0]) * longint'(x);
    for (int k = 1; k < FF_TAPS; k++) acc += longint'(ff_w[k]) * longint'(x_hist[k-1]);
    for (int j = 1; j < FB_TAPS; j++) acc -= longint'(fb_w[j]) * longint'(y_hist[j-1]);
    // round half up, then floor shift
    q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    clip = 1'b0;
    if (q > longint'(S_MAX)) begin
      q = longint'(S_MAX);
      clip = 1'b1;
    end else if (q < longint'(S_MIN)) begin
      q = longint'(S_MIN);
      clip = 1'b1;
    end
    y = sample_t'(q);
    for (int k = FF_TAPS - 2; k > 0; k--) x_hist[k] = x_hist[k-1];
    x_hist[0] = x;
    for (int j = FB_TAPS - 2; j > 0; j--) y_hist[j] = y_hist[j-1];
    y_hist[0] = y;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  function automatic void add_word(input sample_t v, input logic s);
    plan_row_t r;
    r.kind = ROW_WORD; r.value = v; r.start = s; r.reg_idx = 0;
    r.typed = 1'b0; r.exp_sample = '0; r.exp_clip = 1'b0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_known(input sample_t v, input logic s,
                                    input sample_t es, input logic ec);
    plan_row_t r;
    r.kind = ROW_WORD; r.value = v; r.start = s; r.reg_idx = 0;
    r.typed = 1'b1; r.exp_sample = es; r.exp_clip = ec;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_reg(input int unsigned idx, input logic [15:0] v);
    plan_row_t r;
    r.kind = ROW_REG; r.value = v; r.start = 1'b0; r.reg_idx = idx;
    r.typed = 1'b0; r.exp_sample = '0; r.exp_clip = 1'b0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void build_plan();
    // reset coefficients: y = 0.5x + 0.2x[-1] + 0.5y[-1]
    add_known(16'sd0, 1'b1, 16'sd0, 1'b0);
    add_known(S_MAX, 1'b1, 16'sd16384, 1'b0);
    add_known(S_MIN, 1'b1, -16'sd16384, 1'b0);
    add_known(16'sd1, 1'b1, 16'sd1, 1'b0);      // tie rounds up
    add_known(-16'sd1, 1'b1, 16'sd0, 1'b0);     // tie rounds toward plus infinity
    add_word(16'sd12345, 1'b0);
    add_word(-16'sd20000, 1'b0);
    add_word(S_MAX, 1'b0);
    add_word(S_MAX, 1'b0);
    // all gains at the extremes, feedback adds: saturation both ways
    add_reg(REG_FF_COEF_0, C_MAX);
    add_reg(REG_FF_COEF_1, C_MAX);
    add_reg(REG_FF_COEF_2, C_MAX);
    add_reg(REG_FF_COEF_3, C_MAX);
    add_reg(REG_FB_COEF_1, C_MIN);
    add_reg(REG_FB_COEF_2, C_MIN);
    add_reg(REG_FB_COEF_3, C_MIN);
    add_reg(REG_UNMAPPED, 16'h1234);            // ignored
    add_known(S_MAX, 1'b1, S_MAX, 1'b1);
    add_word(S_MAX, 1'b0);
    add_known(S_MIN, 1'b1, S_MIN, 1'b1);
    add_word(S_MIN, 1'b0);
    add_word(16'sd0, 1'b0);
    // opposite extremes
    add_reg(REG_FF_COEF_0, C_MIN);
    add_reg(REG_FF_COEF_1, C_MIN);
    add_reg(REG_FF_COEF_2, C_MIN);
    add_reg(REG_FF_COEF_3, C_MIN);
    add_reg(REG_FB_COEF_1, C_MAX);
    add_reg(REG_FB_COEF_2, C_MAX);
    add_reg(REG_FB_COEF_3, C_MAX);
    add_known(S_MIN, 1'b1, S_MAX, 1'b1);
    add_known(S_MAX, 1'b1, S_MIN, 1'b1);
    add_word(16'sd5, 1'b0);
    add_word(-16'sd7, 1'b0);
    // unity pass-through
    add_reg(REG_FF_COEF_0, C_ONE);
    add_reg(REG_FF_COEF_1, '0);
    add_reg(REG_FF_COEF_2, '0);
    add_reg(REG_FF_COEF_3, '0);
    add_reg(REG_FB_COEF_1, '0);
    add_reg(REG_FB_COEF_2, '0);
    add_reg(REG_FB_COEF_3, '0);
    add_known(S_MAX, 1'b0, S_MAX, 1'b0);
    add_known(S_MIN, 1'b0, S_MIN, 1'b0);
    add_known(-16'sd1, 1'b0, -16'sd1, 1'b0);
  endfunction

  // ---------------------------------------------------------------------------
  // Random values
  // ---------------------------------------------------------------------------
  function automatic coef_t pick_coef(input logic feedback);
    case ($urandom_range(7))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3, 4:    return coef_t'($urandom);
      default: return feedback ? coef_t'(int'($urandom_range(8192)) - 4096)
                               : coef_t'(int'($urandom_range(16384)) - 8192);
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(4))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          3:       return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      2, 3, 4, 5: return sample_t'($urandom);
      default:    return sample_t'(int'($urandom_range(4096)) - 2048);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One input word; leaves in_tvalid high so words can go back to back
  task automatic send_word(input sample_t v, input logic s, input logic typed,
                           input sample_t es, input logic ec);
    filt_out_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= s;
    do @(posedge clk); while (!in_tready);
    iir_step(v, s, want.sample, want.clip);
    if (typed) begin
      want.sample = es;
      want.clip   = ec;
    end
    pending_outputs.insert(pending_outputs.size(), want);
  endtask

  // One register word; caller lowers cfg_valid after the batch
  task automatic reg_write(input int unsigned idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_coef(idx, v);
  endtask

  // Stop offering words and wait until every output is back
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic configure_random();
    drain_outputs();
    for (int idx = REG_FF_COEF_0; idx <= REG_FB_COEF_3; idx++)
      reg_write(idx, pick_coef(idx >= CFG_FB_BASE));
    if ($urandom_range(2) == 0) reg_write(REG_UNMAPPED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random ready, with an occasional long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= LONG_HOLD - 1;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Output check against the oldest pending expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_out
    filt_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        $error("out word with none expected: out_sample=%0d clipped=%0b",
               $signed(out_tdata), out_tuser[0]);
        mismatches++;
      end else begin
        want = pending_outputs.pop_front();
        if (sample_t'(out_tdata) !== want.sample) begin
          $error("out_sample: expected %0d, actual %0d", want.sample, $signed(out_tdata));
          mismatches++;
        end
        if (out_tuser[0] !== want.clip) begin
          $error("clipped: expected %0b, actual %0b", want.clip, out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int send_pct [0:NUM_PHASES-1];
    int recv_pct [0:NUM_PHASES-1];
    bit cfg_open;
    send_pct = '{27, 70, 0};
    recv_pct = '{70, 27, 0};
    cfg_open = 1'b0;
    coef_defaults();
    build_plan();
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (!cfg_open) begin
          drain_outputs();
          cfg_open = 1'b1;
        end
        reg_write(plan[i].reg_idx, plan[i].value);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_word(sample_t'(plan[i].value), plan[i].start, plan[i].typed,
                  plan[i].exp_sample, plan[i].exp_clip);
      end
    end

    // random streams, new coefficients per segment
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      for (int seg = 0; seg < SEGS_PER_PHASE; seg++) begin
        configure_random();
        // hold the receiver off while words keep coming, to back up the pipe
        if (seg == 1 && ph != 1) holds_asked++;
        for (int n = 0; n < SEG_WORDS; n++)
          send_word(pick_sample(), $urandom_range(39) == 0, 1'b0, '0, 1'b0);
      end
    end

    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
